// ===== rtl/core/skrf_pkg.sv =====
// ----------------------------------------------------------------------------
// skrf_pkg
// Shared types, constants and the microcode table of the scalar Kalman
// rate filter.
// ----------------------------------------------------------------------------
package skrf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned VarW    = 31;
  localparam int unsigned ProdW   = 2 * DataW;
  localparam int unsigned PcW     = 5;
  localparam int unsigned CntW    = $clog2(DataW + 1);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [VarW-1:0] ProcessVarReset = 31'd262144;
  localparam logic [VarW-1:0] SensorVarReset  = 31'd32768;
  localparam logic [VarW-1:0] StartVarReset   = 31'd65536000;
  localparam logic [VarW-1:0] VarMax          = {VarW{1'b1}};
  localparam logic [CntW-1:0] DivSteps        = CntW'(DataW);

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROCESS_VAR = 2'd0,
    REG_SENSOR_VAR  = 2'd1,
    REG_START_VAR   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_ODOM = 1'b0,
    KIND_GYRO = 1'b1
  } sample_kind_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_FETCH,
    UOP_GYRO,
    UOP_SEED,
    UOP_CHANGE,
    UOP_MEAN,
    UOP_DENOM,
    UOP_MUL_RM,
    UOP_MUL_PG,
    UOP_ADD,
    UOP_MUL_RP,
    UOP_DIV_START,
    UOP_WRITEBACK,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_GYRO,
    COND_FIRST,
    COND_DENOM_ZERO,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_e;

  // program addresses
  localparam logic [PcW-1:0] StepFetch     = 5'd0;
  localparam logic [PcW-1:0] StepDispatch  = 5'd1;
  localparam logic [PcW-1:0] StepFirst     = 5'd2;
  localparam logic [PcW-1:0] StepChange    = 5'd3;
  localparam logic [PcW-1:0] StepMean      = 5'd4;
  localparam logic [PcW-1:0] StepDenom     = 5'd5;
  localparam logic [PcW-1:0] StepMulRm     = 5'd6;
  localparam logic [PcW-1:0] StepMulPg     = 5'd7;
  localparam logic [PcW-1:0] StepAdd       = 5'd8;
  localparam logic [PcW-1:0] StepMulRp     = 5'd9;
  localparam logic [PcW-1:0] StepDivStart  = 5'd10;
  localparam logic [PcW-1:0] StepDivWait   = 5'd11;
  localparam logic [PcW-1:0] StepWriteback = 5'd12;
  localparam logic [PcW-1:0] StepOutWait   = 5'd13;
  localparam logic [PcW-1:0] StepEmit      = 5'd14;
  localparam logic [PcW-1:0] StepGyro      = 5'd15;
  localparam logic [PcW-1:0] StepSeed      = 5'd16;
  localparam logic [PcW-1:0] StepLast      = StepSeed;

  typedef struct packed {
    uop_e           uop;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic req;
    logic gyro;
    logic first;
    logic denom_zero;
    logic div_busy;
    logic out_busy;
  } status_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_word_t microcode(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      StepFetch:     w = '{UOP_FETCH,     COND_NO_REQ,     StepFetch};
      StepDispatch:  w = '{UOP_NOP,       COND_GYRO,       StepGyro};
      StepFirst:     w = '{UOP_NOP,       COND_FIRST,      StepSeed};
      StepChange:    w = '{UOP_CHANGE,    COND_NEVER,      StepFetch};
      StepMean:      w = '{UOP_MEAN,      COND_NEVER,      StepFetch};
      StepDenom:     w = '{UOP_DENOM,     COND_NEVER,      StepFetch};
      StepMulRm:     w = '{UOP_MUL_RM,    COND_DENOM_ZERO, StepOutWait};
      StepMulPg:     w = '{UOP_MUL_PG,    COND_NEVER,      StepFetch};
      StepAdd:       w = '{UOP_ADD,       COND_NEVER,      StepFetch};
      StepMulRp:     w = '{UOP_MUL_RP,    COND_NEVER,      StepFetch};
      StepDivStart:  w = '{UOP_DIV_START, COND_NEVER,      StepFetch};
      StepDivWait:   w = '{UOP_NOP,       COND_DIV_BUSY,   StepDivWait};
      StepWriteback: w = '{UOP_WRITEBACK, COND_NEVER,      StepFetch};
      StepOutWait:   w = '{UOP_NOP,       COND_OUT_BUSY,   StepOutWait};
      StepEmit:      w = '{UOP_EMIT,      COND_ALWAYS,     StepFetch};
      StepGyro:      w = '{UOP_GYRO,      COND_ALWAYS,     StepFetch};
      StepSeed:      w = '{UOP_SEED,      COND_ALWAYS,     StepFetch};
      default:       w = '{UOP_NOP,       COND_ALWAYS,     StepFetch};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/skrf_div.sv =====
// ----------------------------------------------------------------------------
// skrf_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// DataW bits, so the upper half of the dividend is below the divisor.
// ----------------------------------------------------------------------------
module skrf_div
  import skrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             busy_o,
  output logic [DataW-1:0] quotient_o
);

  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] low_q, low_d;
  logic [DataW-1:0] dvsr_q;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             ge;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = low_q;

  // low_q shifts dividend bits out and quotient bits in
  always_comb begin
    trial = {rem_q, low_q[DataW-1]};
    ge    = (trial >= {1'b0, dvsr_q});
    diff  = trial - {1'b0, dvsr_q};
    rem_d = ge ? diff[DataW-1:0] : trial[DataW-1:0];
    low_d = {low_q[DataW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DivSteps;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i[ProdW-1:DataW];
      low_q  <= dividend_i[DataW-1:0];
      dvsr_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

endmodule

// ===== rtl/core/skrf_seq.sv =====
// ----------------------------------------------------------------------------
// skrf_seq
// Step counter and control store: fetches one control word per cycle and
// resolves conditional jumps from datapath status.
// ----------------------------------------------------------------------------
module skrf_seq
  import skrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  status_t    status_i,
  output ctrl_word_t ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  ctrl_word_t     ctrl;
  logic           take;

  assign ctrl   = microcode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_REQ:     take = !status_i.req;
      COND_GYRO:       take = status_i.gyro;
      COND_FIRST:      take = status_i.first;
      COND_DENOM_ZERO: take = status_i.denom_zero;
      COND_DIV_BUSY:   take = status_i.div_busy;
      COND_OUT_BUSY:   take = status_i.out_busy;
      default:         take = 1'b1;
    endcase
    pc_d = take ? ctrl.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepFetch;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= StepLast)
    else $error("step counter left the program");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.uop == UOP_FETCH && status_i.req) |=> (pc_q == StepDispatch))
    else $error("accepted request not dispatched");
`endif

endmodule

// ===== rtl/core/skrf_datapath.sv =====
// ----------------------------------------------------------------------------
// skrf_datapath
// Filter state, config registers, saturating adders, shared multiplier,
// two dividers and the output register, all steered by the control word.
// ----------------------------------------------------------------------------
module skrf_datapath
  import skrf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_word_t              ctrl_i,
  output status_t                 status_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [VarW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic signed [DataW-1:0] rate_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] estimate_o,
  output logic [VarW-1:0]         estimate_variance_o
);

  function automatic logic signed [DataW-1:0] sat_sum(input logic signed [DataW:0] s);
    logic signed [DataW-1:0] r;
    if (s[DataW] != s[DataW-1]) begin
      r = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

  logic [VarW-1:0]         process_q, sensor_q, start_q;
  logic signed [DataW-1:0] mean_q, gyro_q, odom_q;
  logic [VarW-1:0]         var_q;
  logic                    first_q;
  sample_kind_e            kind_q;
  logic signed [DataW-1:0] sample_q;
  logic signed [DataW-1:0] chg_q;
  logic [DataW-1:0]        denom_q;
  logic signed [ProdW-1:0] prod_q, acc_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] est_q;
  logic [VarW-1:0]         evar_q;

  logic signed [DataW-1:0] chg_sat, mean_sat;
  logic [DataW-1:0]        pvar_sum;
  logic [VarW-1:0]         pvar;
  logic [DataW-1:0]        denom;
  logic signed [DataW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] product;
  logic [ProdW-1:0]        acc_mag;
  logic                    div_start;
  logic                    busy_mean, busy_var;
  logic [DataW-1:0]        q_mean, q_var;
  logic signed [DataW-1:0] mean_wb;

  assign chg_sat  = sat_sum({sample_q[DataW-1], sample_q} - {odom_q[DataW-1], odom_q});
  assign mean_sat = sat_sum({mean_q[DataW-1], mean_q} + {chg_q[DataW-1], chg_q});
  assign pvar_sum = {1'b0, var_q} + {1'b0, process_q};
  assign pvar     = pvar_sum[DataW-1] ? VarMax : pvar_sum[VarW-1:0];
  assign denom    = {1'b0, sensor_q} + {1'b0, var_q};

  // one shared multiplier, operands picked by the step
  always_comb begin
    case (ctrl_i.uop)
      UOP_MUL_PG: begin
        mul_a = {1'b0, var_q};
        mul_b = gyro_q;
      end
      UOP_MUL_RP: begin
        mul_a = {1'b0, sensor_q};
        mul_b = {1'b0, var_q};
      end
      default: begin
        mul_a = {1'b0, sensor_q};
        mul_b = mean_q;
      end
    endcase
  end

  assign product   = ProdW'(mul_a) * ProdW'(mul_b);
  assign acc_mag   = acc_q[ProdW-1] ? ProdW'(-acc_q) : ProdW'(acc_q);
  assign div_start = (ctrl_i.uop == UOP_DIV_START);
  assign mean_wb   = neg_q ? -q_mean : q_mean;

  skrf_div u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (denom_q),
    .busy_o     (busy_mean),
    .quotient_o (q_mean)
  );

  skrf_div u_div_var (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (denom_q),
    .busy_o     (busy_var),
    .quotient_o (q_var)
  );

  assign in_ready_o          = (ctrl_i.uop == UOP_FETCH);
  assign out_valid_o         = out_valid_q;
  assign estimate_o          = est_q;
  assign estimate_variance_o = evar_q;

  assign status_o = '{
    req:        in_valid_i,
    gyro:       (kind_q == KIND_GYRO),
    first:      first_q,
    denom_zero: (denom_q == '0),
    div_busy:   busy_mean | busy_var,
    out_busy:   out_valid_q & ~out_ready_i
  };

  // config and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      process_q   <= ProcessVarReset;
      sensor_q    <= SensorVarReset;
      start_q     <= StartVarReset;
      mean_q      <= '0;
      var_q       <= StartVarReset;
      gyro_q      <= '0;
      odom_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_PROCESS_VAR: process_q <= cfg_data_i;
          REG_SENSOR_VAR:  sensor_q  <= cfg_data_i;
          REG_START_VAR:   start_q   <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (ctrl_i.uop)
        UOP_GYRO:      gyro_q <= sample_q;
        UOP_SEED: begin
          mean_q  <= sample_q;
          odom_q  <= sample_q;
          var_q   <= start_q;
          first_q <= 1'b0;
        end
        UOP_CHANGE: begin
          odom_q <= sample_q;
          var_q  <= pvar;
        end
        UOP_MEAN:      mean_q <= mean_sat;
        UOP_WRITEBACK: begin
          mean_q <= mean_wb;
          var_q  <= q_var[VarW-1:0];
        end
        default: ;
      endcase
      if (ctrl_i.uop == UOP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.uop)
      UOP_FETCH: begin
        if (in_valid_i) begin
          kind_q   <= sample_kind_e'(op_i);
          sample_q <= rate_sample_i;
        end
      end
      UOP_CHANGE: chg_q   <= chg_sat;
      UOP_DENOM:  denom_q <= denom;
      UOP_MUL_RM: prod_q  <= product;
      UOP_MUL_PG: begin
        acc_q  <= prod_q;
        prod_q <= product;
      end
      UOP_ADD:    acc_q <= acc_q + prod_q;
      UOP_MUL_RP: begin
        prod_q <= product;
        acc_q  <= acc_mag;
        neg_q  <= acc_q[ProdW-1];
      end
      UOP_EMIT: begin
        est_q  <= mean_q;
        evar_q <= var_q;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_var_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.uop == UOP_WRITEBACK) |-> (q_var <= {1'b0, sensor_q}))
    else $error("corrected variance above sensor variance");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.uop == UOP_EMIT) |=> (out_valid_q && est_q == $past(mean_q)))
    else $error("emit step did not load the estimate");
`endif

endmodule

// ===== rtl/core/scalar_kalman_rate_filter_unit.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_rate_filter_unit
// One-dimensional Kalman filter for yaw rate, microcoded.
// ----------------------------------------------------------------------------
// A gyro request (op 1) only stores the sample. The first odometry request
// (op 0) after reset seeds the estimate from its sample and the variance
// from start_variance and gives no result. Each later odometry request
// predicts (estimate moves by the odometry change, variance grows by
// process_variance), corrects with the latest gyro sample and returns one
// result. The divide runs in two restoring dividers side by side at one
// quotient bit per cycle, and the result waits while the previous result is
// still held in the output register. When sensor_variance and the predicted
// variance are both zero the divide is skipped. Estimates are signed Q16.16,
// variances unsigned Q15.16, and sums saturate. A finished result waits in
// an output register while the next request is taken.
// Write the config registers only while the block is idle.
// ----------------------------------------------------------------------------
module scalar_kalman_rate_filter_unit
  import skrf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [VarW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic signed [DataW-1:0] rate_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] estimate_o,
  output logic [VarW-1:0]         estimate_variance_o
);

  ctrl_word_t ctrl;
  status_t    status;

  skrf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  skrf_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .status_o            (status),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .op_i                (op_i),
    .rate_sample_i       (rate_sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .estimate_o          (estimate_o),
    .estimate_variance_o (estimate_variance_o)
  );

endmodule

// ===== test/skrf_rate_checker.sv =====
// ----------------------------------------------------------------------------
// skrf_rate_checker
// Watches the config port and the request and result channels of the scalar
// Kalman rate filter. It keeps its own filter state, computes the result of
// each odometry request after the seeding one and compares the returned estimate and variance in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module skrf_rate_checker
  import skrf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [VarW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    op_i,
  input  logic signed [DataW-1:0] rate_sample_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [DataW-1:0] estimate_i,
  input  logic [VarW-1:0]         estimate_variance_i,
  output int unsigned             pending_o,
  output int unsigned             fail_count_o
);

  localparam int unsigned ReportLimit = 10;
  localparam logic signed [DataW-1:0] RateMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] RateMin = 32'sh80000000;

  typedef struct packed {
    logic signed [DataW-1:0] estimate;
    logic [VarW-1:0]         variance;
  } rate_result_t;

  logic [VarW-1:0]         process_var_q;
  logic [VarW-1:0]         sensor_var_q;
  logic [VarW-1:0]         start_var_q;
  logic signed [DataW-1:0] est_mean;
  logic [DataW-1:0]        est_var;
  logic signed [DataW-1:0] gyro_last;
  logic signed [DataW-1:0] odom_last;
  logic                    seed_pending;
  rate_result_t            expected_rates[$];
  int unsigned             fail_count;

  function automatic logic signed [DataW-1:0] clamp_rate(input longint v);
    if (v > 64'sd2147483647) return RateMax;
    if (v < -64'sd2147483648) return RateMin;
    return v[DataW-1:0];
  endfunction

  // predict with the odometry change, then blend in the latest gyro rate
  task automatic update_estimate(input logic signed [DataW-1:0] sample);
    logic signed [DataW-1:0] change;
    longint                  pvar;
    longint                  rv;
    longint                  mv;
    longint                  gv;
    longint                  denom;
    longint                  quo;
    longint                  vq;
    rate_result_t            res;
    mv = sample;
    gv = odom_last;
    change = clamp_rate(mv - gv);
    odom_last = sample;
    mv = est_mean;
    gv = change;
    est_mean = clamp_rate(mv + gv);
    pvar = est_var;
    rv = process_var_q;
    pvar = pvar + rv;
    if (pvar > VarMax) pvar = VarMax;
    est_var = pvar[DataW-1:0];

    rv = sensor_var_q;
    denom = rv + pvar;
    // zero denominator keeps the predicted values
    if (denom != 0) begin
      mv = est_mean;
      gv = gyro_last;
      quo = (rv * mv + pvar * gv) / denom;
      vq = (rv * pvar) / denom;
      est_mean = clamp_rate(quo);
      est_var = (vq > VarMax) ? DataW'(VarMax) : vq[DataW-1:0];
    end
    res.estimate = est_mean;
    res.variance = est_var[VarW-1:0];
    expected_rates.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rate_result_t want;
    if (!rst_ni) begin
      process_var_q = ProcessVarReset;
      sensor_var_q  = SensorVarReset;
      start_var_q   = StartVarReset;
      est_mean      = '0;
      est_var       = DataW'(StartVarReset);
      gyro_last     = '0;
      odom_last     = '0;
      seed_pending  = 1'b1;
      expected_rates.delete();
      fail_count    = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROCESS_VAR: process_var_q = cfg_data_i;
          REG_SENSOR_VAR:  sensor_var_q  = cfg_data_i;
          REG_START_VAR:   start_var_q   = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_rates.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("%0t: unexpected result estimate %0d variance %0d", $time,
                     estimate_i, estimate_variance_i);
        end else begin
          want = expected_rates.pop_front();
          if (estimate_i !== want.estimate || estimate_variance_i !== want.variance) begin
            fail_count++;
            if (fail_count <= ReportLimit)
              $display("%0t: mismatch estimate exp %0d got %0d, variance exp %0d got %0d",
                       $time, want.estimate, estimate_i, want.variance,
                       estimate_variance_i);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (op_i == KIND_GYRO) begin
          gyro_last = rate_sample_i;
        end else if (seed_pending) begin
          est_mean     = rate_sample_i;
          odom_last    = rate_sample_i;
          est_var      = DataW'(start_var_q);
          seed_pending = 1'b0;
        end else begin
          update_estimate(rate_sample_i);
        end
      end

      pending_o    <= expected_rates.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

// ===== test/tb_scalar_kalman_rate_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_scalar_kalman_rate_filter_unit
// Drives gyro and odometry requests into the rate filter under several
// variance settings, with random gaps on both channels, and lets the
// checker compare every result against its own filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_scalar_kalman_rate_filter_unit;
  import skrf_pkg::*;

  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned SettleCycles  = 60;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned ItemsPerPhase = 160;
  localparam logic [CfgIdxW-1:0]      RegUnused = 2'd3;
  localparam logic signed [DataW-1:0] RateMax   = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] RateMin   = 32'sh80000000;
  localparam logic signed [DataW-1:0] RateOne   = 32'sh00010000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [VarW-1:0]         cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    op_i;
  logic signed [DataW-1:0] rate_sample_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] estimate_o;
  logic [VarW-1:0]         estimate_variance_o;

  int unsigned pending_rates;
  int unsigned fail_count;
  int unsigned stall_cycles = 0;
  int unsigned ready_hold = 0;
  logic        calm;

  scalar_kalman_rate_filter_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .rate_sample_i,
    .out_valid_o,
    .out_ready_i,
    .estimate_o,
    .estimate_variance_o
  );

  skrf_rate_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i          (in_ready_o),
    .op_i,
    .rate_sample_i,
    .out_valid_i         (out_valid_o),
    .out_ready_i,
    .estimate_i          (estimate_o),
    .estimate_variance_i (estimate_variance_o),
    .pending_o           (pending_rates),
    .fail_count_o        (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(16, 80);
  endfunction

  function automatic logic [VarW-1:0] pick_variance();
    logic [DataW-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VarMax;
      2, 3, 4: return VarW'($urandom_range(1, 32'h0010_0000));
      5, 6:    return VarW'($urandom_range(32'h0010_0000, 32'h0400_0000));
      default: return raw[VarW-1:0];
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_rate();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = RateMax;
      1:       v = RateMin;
      2, 3, 4: v = $urandom;
      default: v = $urandom_range(0, 32'h003f_ffff) - 32'sh0020_0000;
    endcase
    return v;
  endfunction

  // receiver side stalls
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_hold = pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // leaves valid high after acceptance so back-to-back requests need no toggle
  task automatic send_sample(input sample_kind_e kind, input logic signed [DataW-1:0] value);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= kind;
    rate_sample_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending, wait for every outstanding result, then an optional quiet time
  task automatic settle(input int unsigned extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rates != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [VarW-1:0] process_var,
                               input logic [VarW-1:0] sensor_var,
                               input logic [VarW-1:0] start_var);
    settle(SettleCycles);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PROCESS_VAR;
    cfg_data_i <= process_var;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SENSOR_VAR;
    cfg_data_i <= sensor_var;
    @(posedge clk_i);
    cfg_idx_i  <= REG_START_VAR;
    cfg_data_i <= start_var;
    @(posedge clk_i);
    // unmapped index must leave everything alone
    cfg_idx_i  <= RegUnused;
    cfg_data_i <= ~sensor_var;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [VarW-1:0] sensor_var;
    sample_kind_e    kind;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PROCESS_VAR;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    op_i          = KIND_ODOM;
    rate_sample_i = '0;
    calm          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tiny variances, huge start variance so prediction saturates
    load_settings(31'd1, 31'd1, VarMax);
    send_sample(KIND_GYRO, RateMax);
    send_sample(KIND_ODOM, RateMin);
    send_sample(KIND_ODOM, RateMax);
    send_sample(KIND_GYRO, RateMin);
    send_sample(KIND_ODOM, RateMin);
    send_sample(KIND_ODOM, '0);
    send_sample(KIND_GYRO, '0);
    send_sample(KIND_ODOM, RateMax);
    send_sample(KIND_ODOM, RateMax);
    send_sample(KIND_GYRO, 32'sd1);
    send_sample(KIND_ODOM, -32'sd1);
    send_sample(KIND_ODOM, 32'sd1);

    // largest variances; start variance changes after seeding are ignored
    load_settings(VarMax, VarMax, '0);
    send_sample(KIND_ODOM, RateMin);
    send_sample(KIND_GYRO, RateMax);
    send_sample(KIND_ODOM, RateMax);
    send_sample(KIND_ODOM, '0);

    // both variances zero: second update hits the zero denominator
    load_settings('0, '0, StartVarReset);
    send_sample(KIND_ODOM, RateOne);
    send_sample(KIND_GYRO, 3 * RateOne);
    send_sample(KIND_ODOM, -RateOne);
    send_sample(KIND_ODOM, '0);

    for (int p = 0; p < PhaseCount; p++) begin
      sensor_var = pick_variance();
      if (sensor_var == '0) sensor_var = 31'd1;
      case (p % 4)
        0:       load_settings(VarMax, 31'd1, pick_variance());
        1:       load_settings('0, VarMax, pick_variance());
        2:       load_settings(ProcessVarReset, SensorVarReset, StartVarReset);
        default: load_settings(pick_variance(), sensor_var, pick_variance());
      endcase
      calm <= (p % 3 == 1);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        kind = ($urandom_range(0, 9) < 4) ? KIND_GYRO : KIND_ODOM;
        if ($urandom_range(0, 49) == 0) settle(0);
        send_sample(kind, pick_rate());
      end
    end

    settle(SettleCycles);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
